FILE: design/mips_subset_single_cycle_core_defines.svh
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define MSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define MSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int ROW_AW = MEM_AW - 2;
  localparam int ROWS = MEM_BYTES / 4;

  typedef logic [31:0] word_t;
  typedef logic [4:0] reg_idx_t;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [2:0] ALU_ADD = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_OR  = 3'd5;
  localparam logic [2:0] ALU_NOR = 3'd7;

  localparam word_t HALT_WORD = 32'hffff_ffff;
  localparam word_t MEM_LIMIT = word_t'(MEM_BYTES);

  function automatic word_t alu(input logic [2:0] op, input word_t a, input word_t b);
    word_t r;
    unique case (op)
      ALU_ADD: r = a + b;
      ALU_SUB: r = a - b;
      ALU_AND: r = a & b;
      ALU_OR:  r = a | b;
      ALU_NOR: r = ~(a | b);
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

FILE: design/mips_subset_single_cycle_core.sv
`timescale 1ns / 1ps
// Small MIPS-subset core, one instruction or data preload per input transaction.
// Input channel (in_valid/in_ready): mode 1 executes instruction, mode 0 writes
// preload_byte into data memory at preload_address. The instruction word must be
// the one fetched at the previous result's next_pc; the core does not check this.
// Output channel (out_valid/out_ready): one result per transaction with next_pc,
// halted and the register write-back (index and value, zero when none).
// The operand registers are read as a transaction is taken, the execute stage
// then runs it and registers its result in the output register; lw first
// registers its data memory read in the load stage before write-back.
// Throughput: one transaction per cycle while results are taken; lw blocks the
// next one until its load completes, as that one needs the loaded register.
// The output register holds a result until taken; while it is full the execute
// stage waits and in_ready drops, a stalled load still issues its memory read.
// Data memory is four byte-wide banks, one word access per cycle, big-endian,
// addresses wrapping at the memory size.
// Reset (synchronous): pc and stop flag clear, every register reads zero via
// per-entry valid bits; data memory holds no defined contents until written.
`include "mips_subset_single_cycle_core_defines.svh"

module mips_subset_single_cycle_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  msc_pkg::word_t        instruction,
  input  logic [15:0]           preload_address,
  input  logic [7:0]            preload_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output msc_pkg::word_t        next_pc,
  output logic                  halted,
  output logic                  wrote_register,
  output msc_pkg::reg_idx_t     written_index,
  output msc_pkg::word_t        written_value
);

  logic e_valid, l_valid;
  logic mode_q;
  msc_pkg::word_t ins_q;
  logic [15:0] paddr_q;
  logic [7:0] pbyte_q;

  msc_pkg::word_t pc;
  logic stopped;

  msc_pkg::word_t rf [32];
  logic [31:0] rf_vld;
  msc_pkg::word_t ra_raw, rb_raw, byp_val;
  logic ra_byp, rb_byp, ra_vld, rb_vld;

  msc_pkg::reg_idx_t l_idx;
  logic [1:0] l_lo;
  logic [7:0] bank_q [4];
  msc_pkg::word_t ld_word;

  logic run, act, is_halt, rtype, jump, beq, lw, sw, taken;
  logic [5:0] op;
  logic [2:0] aop;
  msc_pkg::word_t simm, opa, opb, pc4, pc_next, res;
  msc_pkg::reg_idx_t dest;
  logic e_wr, e_load, e_store, e_pre, stop_next;

  logic out_free, l_done, e_adv, acc;
  logic wb_en;
  msc_pkg::reg_idx_t wb_idx;
  msc_pkg::word_t wb_val;

  logic mem_we_any, mem_re;
  logic [3:0] bank_we;
  logic [msc_pkg::ROW_AW-1:0] bank_row [4];
  logic [7:0] bank_wd [4];

  // execute stage decode and datapath
  always_comb begin
    op = ins_q[31:26];
    is_halt = (ins_q == msc_pkg::HALT_WORD);
    run = mode_q && !stopped;
    act = run && !is_halt;
    rtype = (op == msc_pkg::OP_RTYPE);
    jump = (op == msc_pkg::OP_J) || (op == msc_pkg::OP_JAL);
    beq = (op == msc_pkg::OP_BEQ);
    lw = (op == msc_pkg::OP_LW);
    sw = (op == msc_pkg::OP_SW);
    simm = {{16{ins_q[15]}}, ins_q[15:0]};
    opa = ra_byp ? byp_val : (ra_vld ? ra_raw : '0);
    opb = rb_byp ? byp_val : (rb_vld ? rb_raw : '0);
    taken = beq && (opa == opb);
    pc4 = pc + 32'd4;
    if (is_halt) begin
      pc_next = pc4;
    end else if (jump) begin
      pc_next = {pc4[31:28], ins_q[25:0], 2'b00};
    end else if (taken) begin
      pc_next = pc4 + {simm[29:0], 2'b00};
    end else begin
      pc_next = pc4;
    end
    if (lw || sw) begin
      aop = msc_pkg::ALU_ADD;
    end else if (rtype) begin
      aop = ins_q[2:0];
    end else begin
      aop = op[2:0];
    end
    res = msc_pkg::alu(aop, opa, rtype ? opb : simm);
    dest = rtype ? ins_q[15:11] : ins_q[20:16];
    e_wr = act && !jump && !beq && !sw && !lw && (dest != '0);
    e_load = act && lw;
    e_store = act && sw;
    e_pre = !mode_q;
    stop_next = is_halt || (pc_next >= msc_pkg::MEM_LIMIT);
  end

  // handshake
  assign out_free = !out_valid || out_ready;
  assign l_done = l_valid && out_free;
  assign e_adv = e_valid && (e_load || out_free);
  assign in_ready = (!l_valid || l_done) && (!e_valid || (e_adv && !e_load));
  assign acc = in_valid && in_ready;

  // register write-back, visible to a transaction taken on the same edge
  assign wb_en = (e_adv && e_wr) || (l_done && (l_idx != '0));
  assign wb_idx = l_valid ? l_idx : dest;
  assign wb_val = l_valid ? ld_word : res;

  // data memory lane addressing, byte k of a word goes to bank (addr + k) mod 4
  assign mem_we_any = e_adv && (e_store || e_pre);
  assign mem_re = e_adv && e_load;

  always_comb begin
    logic [1:0] k;
    logic [msc_pkg::MEM_AW-1:0] base;
    logic [msc_pkg::MEM_AW-1:0] addr;
    logic [msc_pkg::MEM_AW-1:0] paddr;
    base = res[msc_pkg::MEM_AW-1:0];
    paddr = msc_pkg::MEM_AW'(paddr_q);
    for (int j = 0; j < 4; j++) begin
      k = 2'(j) - base[1:0];
      addr = base + msc_pkg::MEM_AW'(k);
      if (e_pre) begin
        bank_row[j] = paddr[msc_pkg::MEM_AW-1:2];
        bank_wd[j] = pbyte_q;
        bank_we[j] = mem_we_any && (paddr[1:0] == 2'(j));
      end else begin
        bank_row[j] = addr[msc_pkg::MEM_AW-1:2];
        bank_wd[j] = opb[{~k, 3'b000} +: 8];
        bank_we[j] = mem_we_any;
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [msc_pkg::ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        mem[bank_row[g]] <= bank_wd[g];
      end
      if (mem_re) begin
        bank_q[g] <= mem[bank_row[g]];
      end
    end
  end

  always_comb begin
    ld_word = '0;
    for (int kk = 0; kk < 4; kk++) begin
      ld_word[{~2'(kk), 3'b000} +: 8] = bank_q[2'(l_lo + 2'(kk))];
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (wb_en) begin
      rf[wb_idx] <= wb_val;
    end
    if (acc) begin
      ra_raw <= rf[instruction[25:21]];
      rb_raw <= rf[instruction[20:16]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      l_valid <= 1'b0;
      out_valid <= 1'b0;
      pc <= '0;
      stopped <= 1'b0;
      rf_vld <= '0;
    end else begin
      e_valid <= acc || (e_valid && !e_adv);
      l_valid <= mem_re || (l_valid && !l_done);
      if (e_adv && run) begin
        pc <= pc_next;
        stopped <= stop_next;
      end
      if (wb_en) begin
        rf_vld[wb_idx] <= 1'b1;
      end
      if ((e_adv && !e_load) || l_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      mode_q <= mode;
      ins_q <= instruction;
      paddr_q <= preload_address;
      pbyte_q <= preload_byte;
      ra_vld <= rf_vld[instruction[25:21]];
      rb_vld <= rf_vld[instruction[20:16]];
      ra_byp <= wb_en && (wb_idx == instruction[25:21]);
      rb_byp <= wb_en && (wb_idx == instruction[20:16]);
      byp_val <= wb_val;
    end
    if (mem_re) begin
      l_idx <= dest;
      l_lo <= res[1:0];
    end
    if (l_done) begin
      next_pc <= pc;
      halted <= stopped;
      wrote_register <= (l_idx != '0);
      written_index <= l_idx;
      written_value <= (l_idx != '0) ? ld_word : '0;
    end else if (e_adv && !e_load) begin
      next_pc <= run ? pc_next : pc;
      halted <= run ? stop_next : stopped;
      wrote_register <= e_wr;
      written_index <= e_wr ? dest : '0;
      written_value <= e_wr ? res : '0;
    end
  end

  `MSC_ASSERT_ALWAYS(a_single_stage, !(e_valid && l_valid), "execute and load stages both busy")
  `MSC_ASSERT_ALWAYS(a_reg_zero, !rf_vld[0], "register zero was written")
  `MSC_ASSERT_NXT(a_accept_exec, in_valid && in_ready, e_valid, "accepted transaction lost")
  `MSC_ASSERT_IMP(a_load_holds, e_valid && e_load, !in_ready, "transaction taken behind a load")

endmodule
